@@ hw/rtl/sama_pkg.sv @@
package sama_pkg;

	localparam int AXES   = 6;
	localparam int AXIS_W = 16;

	typedef struct packed {
		logic signed [AXIS_W-1:0] accel_x;
		logic signed [AXIS_W-1:0] accel_y;
		logic signed [AXIS_W-1:0] accel_z;
		logic signed [AXIS_W-1:0] rate_x;
		logic signed [AXIS_W-1:0] rate_y;
		logic signed [AXIS_W-1:0] rate_z;
	} sample_t;

	typedef struct packed {
		logic signed [AXIS_W-1:0] mean_accel_x;
		logic signed [AXIS_W-1:0] mean_accel_y;
		logic signed [AXIS_W-1:0] mean_accel_z;
		logic signed [AXIS_W-1:0] mean_rate_x;
		logic signed [AXIS_W-1:0] mean_rate_y;
		logic signed [AXIS_W-1:0] mean_rate_z;
	} mean_t;

	typedef logic [AXES-1:0][AXIS_W-1:0] axis_vec_t;

endpackage

@@ hw/rtl/sama_ring.sv @@
module sama_ring #(
	parameter int WINDOW = 20
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        wr_en,
	input  logic [$clog2(WINDOW)-1:0]   slot,
	input  sama_pkg::sample_t           wdata,
	output sama_pkg::sample_t           rdata
);

	sama_pkg::sample_t mem [WINDOW];
	sama_pkg::sample_t rd_q;
	logic [WINDOW-1:0] vld_q;
	logic              hit_q;

	// Read-first: the old entry comes out while the new item goes in
	always_ff @(posedge clk) begin
		if (wr_en) begin
			rd_q      <= mem[slot];
			mem[slot] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			hit_q <= 1'b0;
		end else if (wr_en) begin
			hit_q       <= vld_q[slot];
			vld_q[slot] <= 1'b1;
		end
	end

	// An entry never written holds zero
	assign rdata = hit_q ? rd_q : '0;

endmodule

@@ hw/rtl/sama_div.sv @@
module sama_div #(
	parameter int WINDOW = 20
) (
	input  logic                                        clk,
	input  logic signed [sama_pkg::AXIS_W+$clog2(WINDOW)-1:0] sum,
	input  logic                                        ld_s3,
	input  logic                                        ld_s4,
	output logic [sama_pkg::AXIS_W-1:0]                 quot
);

	localparam int L      = $clog2(WINDOW);
	localparam int N      = sama_pkg::AXIS_W + L;
	localparam int K      = N + L;
	localparam int PROD_W = 2 * N + 1;
	// ceil(2^K / WINDOW): exact floor division for any magnitude below 2^N
	localparam logic [N:0] RECIP =
		(N+1)'(((64'd1 << K) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

	logic [N-1:0]        mag_s3;
	logic                neg_s3;
	logic [PROD_W-1:0]   prod_s4;
	logic                neg_s4;
	logic [sama_pkg::AXIS_W-1:0] q;

	always_ff @(posedge clk) begin
		if (ld_s3) begin
			neg_s3 <= sum[N-1];
			mag_s3 <= sum[N-1] ? N'(-sum) : N'(sum);
		end
		if (ld_s4) begin
			neg_s4  <= neg_s3;
			prod_s4 <= PROD_W'(mag_s3) * PROD_W'(RECIP);
		end
	end

	// Truncate toward zero: divide the magnitude, then restore the sign
	assign q    = prod_s4[K +: sama_pkg::AXIS_W];
	assign quot = neg_s4 ? -q : q;

endmodule

@@ hw/rtl/six_axis_moving_average.sv @@
// Channel | Direction | Handshake                    | Payload
// sample  | in        | sample_valid / sample_stall  | sama_pkg::sample_t
// mean    | out       | mean_valid / mean_stall      | sama_pkg::mean_t
//
// One item per cycle sustained while mean_stall is low; each accepted item's result
// passes through every stage below to mean. Stages: ring read-modify-write, running sum
// update, magnitude, reciprocal multiply, output register.
// Reset clears the running sums, the write slot and the ring's valid bits, so
// unwritten entries read as zero; no clearing pass is needed.
// Empty stages keep filling while the output is stalled; sample_stall rises
// only once every stage holds an item.
module six_axis_moving_average #(
	parameter int WINDOW = 20
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	input  sama_pkg::sample_t  sample,
	output logic               mean_valid,
	input  logic               mean_stall,
	output sama_pkg::mean_t    mean
);

	localparam int SLOT_W = $clog2(WINDOW);
	localparam int SUM_W  = sama_pkg::AXIS_W + $clog2(WINDOW);

	logic              en1, en2, en3, en4, out_en;
	logic              accept;
	logic              v1_s1, v2_s2, v3_s3, v4_s4;
	logic [SLOT_W-1:0] slot_q;
	sama_pkg::sample_t new_s1;
	sama_pkg::sample_t old_s1;
	sama_pkg::axis_vec_t new_vec, old_vec, quot_vec;
	logic signed [SUM_W-1:0] sum_q [sama_pkg::AXES];
	sama_pkg::mean_t   mean_q;
	logic              mean_valid_q;

	assign out_en       = !mean_valid_q || !mean_stall;
	assign en4          = !v4_s4 || out_en;
	assign en3          = !v3_s3 || en4;
	assign en2          = !v2_s2 || en3;
	assign en1          = !v1_s1 || en2;
	assign sample_stall = !en1;
	assign accept       = sample_valid && en1;

	sama_ring #(.WINDOW(WINDOW)) u_ring (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (accept),
		.slot   (slot_q),
		.wdata  (sample),
		.rdata  (old_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q       <= '0;
			v1_s1        <= 1'b0;
			v2_s2        <= 1'b0;
			v3_s3        <= 1'b0;
			v4_s4        <= 1'b0;
			mean_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
			end
			if (en1) v1_s1 <= accept;
			if (en2) v2_s2 <= v1_s1;
			if (en3) v3_s3 <= v2_s2;
			if (en4) v4_s4 <= v3_s3;
			if (out_en) mean_valid_q <= v4_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) new_s1 <= sample;
		if (out_en && v4_s4) mean_q <= sama_pkg::mean_t'(quot_vec);
	end

	assign new_vec = sama_pkg::axis_vec_t'(new_s1);
	assign old_vec = sama_pkg::axis_vec_t'(old_s1);

	for (genvar a = 0; a < sama_pkg::AXES; a++) begin : g_axis
		// Add the incoming sample, drop the one it displaces
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sum_q[a] <= '0;
			end else if (en2 && v1_s1) begin
				sum_q[a] <= sum_q[a]
					+ {{(SUM_W-sama_pkg::AXIS_W){new_vec[a][sama_pkg::AXIS_W-1]}}, new_vec[a]}
					- {{(SUM_W-sama_pkg::AXIS_W){old_vec[a][sama_pkg::AXIS_W-1]}}, old_vec[a]};
			end
		end

		sama_div #(.WINDOW(WINDOW)) u_div (
			.clk   (clk),
			.sum   (sum_q[a]),
			.ld_s3 (en3),
			.ld_s4 (en4),
			.quot  (quot_vec[a])
		);
	end

	assign mean_valid = mean_valid_q;
	assign mean       = mean_q;

endmodule
